### rtl/tvso_pkg.sv
// ----------------------------------------------------------------------------
// Three-voice sine oscillator package
// Register indexes, reset values and the sine table generator shared by the
// oscillator core and its sine table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tvso_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int VOL_BITS       = 16;
    localparam int INC_BITS       = 32;
    localparam int START_BITS     = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOICE0_INCREMENT   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOICE1_INCREMENT   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOICE2_INCREMENT   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOICE0_VOLUME      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOICE1_VOLUME      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOICE2_VOLUME      = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOICE1_START_PHASE = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOICE2_START_PHASE = 3'd7;

    // Register reset values.
    localparam logic [INC_BITS-1:0]   RESET_INCREMENT0 = 32'd42852281;
    localparam logic [INC_BITS-1:0]   RESET_INCREMENT1 = 32'd21377448;
    localparam logic [INC_BITS-1:0]   RESET_INCREMENT2 = 32'd128576318;
    localparam logic [VOL_BITS-1:0]   RESET_VOLUME0    = 16'd16384;
    localparam logic [VOL_BITS-1:0]   RESET_VOLUME1    = 16'd9830;
    localparam logic [VOL_BITS-1:0]   RESET_VOLUME2    = 16'd9830;
    localparam logic [START_BITS-1:0] RESET_START1     = 32'd2540740887;
    localparam logic [START_BITS-1:0] RESET_START2     = 32'd786514478;

    // Unity gain in Q1.15; larger volumes saturate to it.
    localparam logic [VOL_BITS:0] VOL_MAX = 17'd32768;

    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Sine of (pi/2)*j/2^quarter_bits in Q1.(sample_bits-1), from a Taylor
    // polynomial in Q2.30 evaluated in Horner form with truncating steps.
    function automatic int quarter_sine(input int unsigned j, input int quarter_bits,
                                        input int sample_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] amp;
        x   = (HALF_PI_Q30 * 64'(j)) >> quarter_bits;
        x2  = (x * x) >> 30;
        amp = (64'd1 << (sample_bits - 1)) - 64'd1;
        t   = ONE_Q30;
        t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
        t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
        t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s   = (x * t) >> 30;
        return int'((s * amp + (64'd1 << 29)) >> 30);
    endfunction

endpackage

### rtl/tvso_sine_rom.sv
// ----------------------------------------------------------------------------
// Sine table ROM
// Full-wave sine table built at elaboration, read through a registered port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvso_sine_rom #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [ADDR_BITS-1:0]        addr,
    output logic signed [DATA_BITS-1:0] data
);
    import tvso_pkg::*;

    localparam int TABLE_SIZE   = 1 << ADDR_BITS;
    localparam int QUARTER_BITS = ADDR_BITS - 2;
    localparam int QUARTER      = 1 << QUARTER_BITS;

    typedef logic signed [DATA_BITS-1:0] rom_t [TABLE_SIZE];

    // The second quadrant mirrors the first and the second half of the table is negated.
    function automatic rom_t build_rom();
        rom_t        r;
        int unsigned q;
        int unsigned j;
        int          v;
        for (int k = 0; k < TABLE_SIZE; k++)
        begin
            q = k >> QUARTER_BITS;
            j = k & (QUARTER - 1);
            if (q[0])
            begin
                v = quarter_sine(QUARTER - j, QUARTER_BITS, DATA_BITS);
            end
            else
            begin
                v = quarter_sine(j, QUARTER_BITS, DATA_BITS);
            end
            r[k] = q[1] ? DATA_BITS'(-v) : DATA_BITS'(v);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic signed [DATA_BITS-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= SINE_ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

### rtl/three_voice_sine_oscillator_mixer_core.sv
// ----------------------------------------------------------------------------
// Three-voice sine oscillator and mixer
// Every input transaction yields one output transaction carrying a mixed
// sample: three phase accumulators address a sine table each, every sine is
// scaled by its voice's Q1.15 volume (saturated at unity), and the three
// floored products are summed into a signed Q3.15 sample. Setting restart
// reloads the start phases before that sample is made. The block accepts one
// transaction per cycle unless out_stall holds the pipeline; the rate is set
// by the read-modify-write of the phase memory, which forwards its last
// written word, and the sample passes through the registered sine table read,
// the registered products and the output register.
// The phase memory needs no clearing pass: until its first write it reads as
// the reset phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_voice_sine_oscillator_mixer_core #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  restart,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [SAMPLE_BITS+1:0]         mixed_sample,
    input  logic                                  cfg_write,
    input  logic [tvso_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [tvso_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import tvso_pkg::*;

    localparam int OUT_BITS   = SAMPLE_BITS + 2;
    localparam int PROD_BITS  = SAMPLE_BITS + VOL_BITS + 2;
    localparam int PHASE_WORD = 3 * PHASE_BITS;

    localparam logic [PHASE_WORD-1:0] RESET_WORD =
        {PHASE_BITS'(RESET_START2), PHASE_BITS'(RESET_START1), PHASE_BITS'(0)};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [INC_BITS-1:0]   inc_reg [3];
    logic [VOL_BITS-1:0]   vol_reg [3];
    logic [START_BITS-1:0] start1_reg;
    logic [START_BITS-1:0] start2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg[0] <= RESET_INCREMENT0;
            inc_reg[1] <= RESET_INCREMENT1;
            inc_reg[2] <= RESET_INCREMENT2;
            vol_reg[0] <= RESET_VOLUME0;
            vol_reg[1] <= RESET_VOLUME1;
            vol_reg[2] <= RESET_VOLUME2;
            start1_reg <= RESET_START1;
            start2_reg <= RESET_START2;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_VOICE0_INCREMENT:   inc_reg[0] <= cfg_data;
                REG_VOICE1_INCREMENT:   inc_reg[1] <= cfg_data;
                REG_VOICE2_INCREMENT:   inc_reg[2] <= cfg_data;
                REG_VOICE0_VOLUME:      vol_reg[0] <= cfg_data[VOL_BITS-1:0];
                REG_VOICE1_VOLUME:      vol_reg[1] <= cfg_data[VOL_BITS-1:0];
                REG_VOICE2_VOLUME:      vol_reg[2] <= cfg_data[VOL_BITS-1:0];
                REG_VOICE1_START_PHASE: start1_reg <= cfg_data;
                REG_VOICE2_START_PHASE: start2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage moves when the one after it is free.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;
    logic s1_restart_reg;

    logic ready_out;
    logic ready3;
    logic ready2;
    logic ready1;
    logic phase_we;

    assign ready_out = !out_valid_reg || !out_stall;
    assign ready3    = !s3_valid_reg || ready_out;
    assign ready2    = !s2_valid_reg || ready3;
    assign ready1    = !s1_valid_reg || ready2;
    assign in_stall  = !ready1;
    assign phase_we  = s1_valid_reg && ready2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ready_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            s1_restart_reg <= restart;
        end
    end

    // ------------------------------------------------------------------
    // Phase memory: one word holds all three accumulators. It is read
    // every cycle; a word written at the same edge as the read is taken
    // from the forwarding register instead.
    // ------------------------------------------------------------------
    logic [PHASE_WORD-1:0] phase_mem [1];
    logic [PHASE_WORD-1:0] mem_rdata_reg;
    logic [PHASE_WORD-1:0] fwd_data_reg;
    logic                  fwd_hit_reg;
    logic                  phase_written_reg;
    logic [PHASE_WORD-1:0] phase_wdata;
    logic [PHASE_WORD-1:0] stored_word;

    always_ff @(posedge clk)
    begin
        if (phase_we)
        begin
            phase_mem[0] <= phase_wdata;
        end
        mem_rdata_reg <= phase_mem[0];
        fwd_data_reg  <= phase_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg       <= 1'b0;
            phase_written_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= phase_we;
            if (phase_we)
            begin
                phase_written_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            stored_word = fwd_data_reg;
        end
        else if (phase_written_reg)
        begin
            stored_word = mem_rdata_reg;
        end
        else
        begin
            stored_word = RESET_WORD;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: pick the phases, advance them, address the sine tables.
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0]         start_phase [3];
    logic [PHASE_BITS-1:0]         cur_phase   [3];
    logic [PHASE_BITS-1:0]         next_phase  [3];
    logic signed [SAMPLE_BITS-1:0] sine_data   [3];

    assign start_phase[0] = '0;
    assign start_phase[1] = PHASE_BITS'(start1_reg);
    assign start_phase[2] = PHASE_BITS'(start2_reg);

    // ------------------------------------------------------------------
    // Stage 2: scale each sine by its saturated volume.
    // Stage 3: mix the three voices.
    // ------------------------------------------------------------------
    logic [VOL_BITS:0]             vol_sat    [3];
    logic signed [PROD_BITS-1:0]   product    [3];
    logic signed [SAMPLE_BITS-1:0] scaled_reg [3];
    logic signed [OUT_BITS-1:0]    mix_sum;
    logic signed [OUT_BITS-1:0]    mixed_reg;

    for (genvar v = 0; v < 3; v++)
    begin : g_voice
        assign cur_phase[v] = s1_restart_reg ? start_phase[v]
                                             : stored_word[v*PHASE_BITS +: PHASE_BITS];
        assign next_phase[v] = cur_phase[v] + PHASE_BITS'(inc_reg[v]);
        assign phase_wdata[v*PHASE_BITS +: PHASE_BITS] = next_phase[v];

        tvso_sine_rom #(
            .ADDR_BITS (TABLE_ADDR_BITS),
            .DATA_BITS (SAMPLE_BITS)
        ) u_sine_rom (
            .clk  (clk),
            .en   (ready2),
            .addr (cur_phase[v][PHASE_BITS-1 -: TABLE_ADDR_BITS]),
            .data (sine_data[v])
        );

        assign vol_sat[v] = ({1'b0, vol_reg[v]} > VOL_MAX) ? VOL_MAX : {1'b0, vol_reg[v]};
        assign product[v] = sine_data[v] * $signed({1'b0, vol_sat[v]});

        // Taking bits above the Q1.15 point floors toward minus infinity.
        always_ff @(posedge clk)
        begin
            if (ready3)
            begin
                scaled_reg[v] <= product[v][15 +: SAMPLE_BITS];
            end
        end
    end

    assign mix_sum = OUT_BITS'(scaled_reg[0]) + OUT_BITS'(scaled_reg[1])
                   + OUT_BITS'(scaled_reg[2]);

    always_ff @(posedge clk)
    begin
        if (ready_out)
        begin
            mixed_reg <= mix_sum;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mixed_sample = mixed_reg;

endmodule
